// File: rtl/core/cmdrl_pkg.sv
// Shared types, register indexes and voltage constants for the command rate limiter.
// No dependencies; every file in rtl/core imports this package.
package cmdrl_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MV_W       = 13;
    localparam int TICK_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_INTERVAL  = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SHORT_INTERVAL_RST = 16'd100;
    localparam logic [CFG_DATA_W-1:0] LONG_INTERVAL_RST  = 16'd2000;

    localparam logic [MV_W-1:0] NEUTRAL_MV = 13'd2500;
    localparam logic [MV_W-1:0] FULL_MV    = 13'd5000;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_PACKET = 1'b1;

    typedef struct packed {
        logic               command;
        logic [31:0]        packet_id;
        logic signed [11:0] lift_lever;
        logic signed [11:0] tilt_lever;
    } in_word_t;

    typedef struct packed {
        logic [MV_W-1:0]    lift_down_mv;
        logic [MV_W-1:0]    lift_up_mv;
        logic [MV_W-1:0]    tilt_back_mv;
        logic [MV_W-1:0]    tilt_fwd_mv;
        logic               is_stop;
        logic signed [31:0] lost_count;
        logic [31:0]        late_count;
        logic [31:0]        sent_count;
    } out_word_t;

    // up voltage = 2500 + 2*lever, clamped to 0..5000 mV
    function automatic logic [MV_W-1:0] lever_to_mv(input logic signed [11:0] lever);
        logic signed [14:0] mv;
        mv = signed'(15'(NEUTRAL_MV)) + 15'(signed'(lever)) + 15'(signed'(lever));
        if (mv < 15'sd0)
            return '0;
        else if (mv > signed'(15'(FULL_MV)))
            return FULL_MV;
        else
            return mv[MV_W-1:0];
    endfunction

endpackage

// File: rtl/core/command_rate_limiter_watchdog_unit.sv
// Command rate limiter with watchdog stop frame: top level and interval registers.
// An accepted word passes the input register, then the result register, before out_valid rises.
// Throughput: one word per cycle unless out_stall holds a result; input and result registers bound the path.
// A result held by out_stall stops the core, so the input stalls once its register is full.
// Reset (rst_n low, async) clears counters, buffer flag and sets intervals 100/2000.
// Depends on cmdrl_pkg, cmdrl_input_stage, cmdrl_core, cmdrl_output_stage.
module command_rate_limiter_watchdog_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  cmdrl_pkg::in_word_t              in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output cmdrl_pkg::out_word_t             out_data,
    input  logic                             cfg_write,
    input  logic [cmdrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cmdrl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cmdrl_pkg::*;

    logic [CFG_DATA_W-1:0] short_reg, short_next;
    logic [CFG_DATA_W-1:0] long_reg, long_next;
    logic                  advance;
    logic                  item_valid;
    in_word_t              item;
    logic                  fire;
    logic                  res_valid;
    out_word_t             res;

    always_comb
    begin
        short_next = short_reg;
        long_next  = long_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_SHORT_INTERVAL: short_next = cfg_data;
                REG_LONG_INTERVAL:  long_next  = cfg_data;
                default:            short_next = short_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg <= SHORT_INTERVAL_RST;
            long_reg  <= LONG_INTERVAL_RST;
        end
        else
        begin
            short_reg <= short_next;
            long_reg  <= long_next;
        end
    end

    assign fire = item_valid && advance;

    cmdrl_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cmdrl_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .item           (item),
        .short_interval (short_reg),
        .long_interval  (long_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    cmdrl_output_stage u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .advance   (advance)
    );

endmodule

// File: rtl/core/cmdrl_input_stage.sv
// Input register for the command rate limiter: captures one word per accept.
// Depends on cmdrl_pkg for the input word type.
module cmdrl_input_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cmdrl_pkg::in_word_t in_data,
    input  logic               advance,
    output logic               item_valid,
    output cmdrl_pkg::in_word_t item
);
    import cmdrl_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     take;

    // slot frees when the held word moves on this cycle
    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            word_reg <= in_data;
    end

    assign item_valid = valid_reg;
    assign item       = word_reg;

endmodule

// File: rtl/core/cmdrl_core.sv
// Rate limiter / watchdog state and per-word decision logic.
// Depends on cmdrl_pkg for word types and lever_to_mv.
module cmdrl_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  cmdrl_pkg::in_word_t             item,
    input  logic [cmdrl_pkg::CFG_DATA_W-1:0] short_interval,
    input  logic [cmdrl_pkg::CFG_DATA_W-1:0] long_interval,
    output logic                            res_valid,
    output cmdrl_pkg::out_word_t            res
);
    import cmdrl_pkg::*;

    logic [TICK_W-1:0] ticks_reg,  ticks_next;
    logic              held_valid_reg, held_valid_next;
    logic [MV_W-1:0]   held_lift_reg, held_lift_next;
    logic [MV_W-1:0]   held_tilt_reg, held_tilt_next;
    logic [31:0]       newest_id_reg, newest_id_next;
    logic              seen_any_reg, seen_any_next;
    logic [31:0]       lost_reg, lost_next;
    logic [31:0]       late_reg, late_next;
    logic [31:0]       sent_reg, sent_next;

    logic [TICK_W-1:0] ticks_inc;
    logic [MV_W-1:0]   new_lift, new_tilt;
    logic [MV_W-1:0]   emit_lift, emit_tilt;
    logic              emit, emit_stop, is_late;

    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;
    assign new_lift  = lever_to_mv(item.lift_lever);
    assign new_tilt  = lever_to_mv(item.tilt_lever);
    assign is_late   = seen_any_reg && (item.packet_id <= newest_id_reg);

    always_comb
    begin
        ticks_next      = ticks_reg;
        held_valid_next = held_valid_reg;
        held_lift_next  = held_lift_reg;
        held_tilt_next  = held_tilt_reg;
        newest_id_next  = newest_id_reg;
        seen_any_next   = seen_any_reg;
        lost_next       = lost_reg;
        late_next       = late_reg;
        emit            = 1'b0;
        emit_stop       = 1'b0;
        emit_lift       = held_lift_reg;
        emit_tilt       = held_tilt_reg;
        if (fire)
        begin
            case (item.command)
                CMD_TICK:
                begin
                    ticks_next = ticks_inc;
                    if (held_valid_reg)
                    begin
                        if (ticks_inc >= short_interval)
                        begin
                            emit            = 1'b1;
                            held_valid_next = 1'b0;
                        end
                    end
                    else if (ticks_inc >= long_interval)
                    begin
                        emit      = 1'b1;
                        emit_stop = 1'b1;
                        emit_lift = NEUTRAL_MV;
                        emit_tilt = NEUTRAL_MV;
                    end
                end
                CMD_PACKET:
                begin
                    if (is_late)
                    begin
                        lost_next = lost_reg - 32'd1;
                        late_next = late_reg + 32'd1;
                    end
                    else
                    begin
                        if (seen_any_reg)
                            lost_next = lost_reg + (item.packet_id - newest_id_reg - 32'd1);
                        newest_id_next = item.packet_id;
                        seen_any_next  = 1'b1;
                        // a held word is always replaced, never sent, by a newer packet
                        if (!held_valid_reg && (ticks_reg > short_interval))
                        begin
                            emit      = 1'b1;
                            emit_lift = new_lift;
                            emit_tilt = new_tilt;
                        end
                        else
                        begin
                            held_valid_next = 1'b1;
                            held_lift_next  = new_lift;
                            held_tilt_next  = new_tilt;
                        end
                    end
                end
                default:
                begin
                    ticks_next = ticks_reg;
                end
            endcase
            if (emit)
                ticks_next = '0;
        end
    end

    assign sent_next = emit ? sent_reg + 32'd1 : sent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg      <= '0;
            held_valid_reg <= 1'b0;
            newest_id_reg  <= '0;
            seen_any_reg   <= 1'b0;
            lost_reg       <= '0;
            late_reg       <= '0;
            sent_reg       <= '0;
        end
        else
        begin
            ticks_reg      <= ticks_next;
            held_valid_reg <= held_valid_next;
            newest_id_reg  <= newest_id_next;
            seen_any_reg   <= seen_any_next;
            lost_reg       <= lost_next;
            late_reg       <= late_next;
            sent_reg       <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_lift_reg <= held_lift_next;
        held_tilt_reg <= held_tilt_next;
    end

    assign res_valid        = emit;
    assign res.lift_down_mv = FULL_MV - emit_lift;
    assign res.lift_up_mv   = emit_lift;
    assign res.tilt_back_mv = FULL_MV - emit_tilt;
    assign res.tilt_fwd_mv  = emit_tilt;
    assign res.is_stop      = emit_stop;
    assign res.lost_count   = signed'(lost_next);
    assign res.late_count   = late_next;
    assign res.sent_count   = sent_next;

    a_send_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (ticks_reg == '0))
        else $error("tick counter not cleared after a send");

    a_held_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> seen_any_reg)
        else $error("buffered word without any accepted packet");

    a_sent_steps: assert property (@(posedge clk) disable iff (!rst_n)
        !emit |=> (sent_reg == $past(sent_reg)))
        else $error("sent counter moved without a send");

    a_late_drop_no_send: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.command == CMD_PACKET && is_late) |-> !emit)
        else $error("late packet produced a word");

endmodule

// File: rtl/core/cmdrl_output_stage.sv
// Result register for the command rate limiter, loaded when the pipeline advances.
// Depends on cmdrl_pkg for the output word type.
module cmdrl_output_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 res_valid,
    input  cmdrl_pkg::out_word_t res,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cmdrl_pkg::out_word_t out_data,
    output logic                 advance
);
    import cmdrl_pkg::*;

    logic      valid_reg, valid_next;
    out_word_t word_reg;

    // register is free when empty or its word leaves this cycle
    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? (load && res_valid) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && load && res_valid)
            word_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_data  = word_reg;

endmodule

// File: sim/cmdrl_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the command rate limiter: predicts each output word from accepted input
// words and register writes, and compares field by field. Depends on cmdrl_pkg.
module cmdrl_checker
    import cmdrl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_word_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_word_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    frames_seen,
    output int                    stops_seen
);

    // predictor copy of the interval registers and limiter state
    logic [15:0] min_gap   = SHORT_INTERVAL_RST;
    logic [15:0] idle_gap  = LONG_INTERVAL_RST;
    logic [15:0] since_send = '0;
    logic        buf_full  = 1'b0;
    logic [MV_W-1:0] buf_lift_mv;
    logic [MV_W-1:0] buf_tilt_mv;
    logic [31:0] top_id    = '0;
    logic        any_id    = 1'b0;
    logic [31:0] lost_acc  = '0;
    logic [31:0] late_acc  = '0;
    logic [31:0] sent_acc  = '0;

    out_word_t frames_due[$];
    int        errors = 0;
    int        frames_checked = 0;
    int        stops_checked = 0;

    initial
    begin
        fail_count  = 0;
        pending     = 0;
        frames_seen = 0;
        stops_seen  = 0;
    end

    function automatic logic [MV_W-1:0] lever_volts(input logic signed [11:0] lever);
        int mv;
        mv = int'(NEUTRAL_MV) + 2 * int'(lever);
        if (mv < 0)
            mv = 0;
        if (mv > int'(FULL_MV))
            mv = int'(FULL_MV);
        return MV_W'(mv);
    endfunction

    task automatic push_frame(input logic [MV_W-1:0] lift_up, input logic [MV_W-1:0] tilt_fwd,
                              input logic stop);
        out_word_t f;
        sent_acc   = sent_acc + 32'd1;
        since_send = '0;
        f.lift_down_mv = FULL_MV - lift_up;
        f.lift_up_mv   = lift_up;
        f.tilt_back_mv = FULL_MV - tilt_fwd;
        f.tilt_fwd_mv  = tilt_fwd;
        f.is_stop      = stop;
        f.lost_count   = lost_acc;
        f.late_count   = late_acc;
        f.sent_count   = sent_acc;
        frames_due.push_back(f);
    endtask

    task automatic drop_stale();
        lost_acc = lost_acc - 32'd1;
        late_acc = late_acc + 32'd1;
    endtask

    // no loss is booked on the very first packet
    task automatic take_id(input logic [31:0] id);
        if (any_id)
            lost_acc = lost_acc + (id - top_id - 32'd1);
        top_id = id;
        any_id = 1'b1;
    endtask

    task automatic step_limiter(input in_word_t w);
        if (w.command == CMD_TICK)
        begin
            if (since_send != 16'hFFFF)
                since_send = since_send + 16'd1;
            if (buf_full)
            begin
                if (since_send >= min_gap)
                begin
                    buf_full = 1'b0;
                    push_frame(buf_lift_mv, buf_tilt_mv, 1'b0);
                end
            end
            else if (since_send >= idle_gap)
                push_frame(NEUTRAL_MV, NEUTRAL_MV, 1'b1);
        end
        else if (!buf_full)
        begin
            if (any_id && w.packet_id <= top_id)
                drop_stale();
            else
            begin
                take_id(w.packet_id);
                if (since_send > min_gap)
                    push_frame(lever_volts(w.lift_lever), lever_volts(w.tilt_lever), 1'b0);
                else
                begin
                    buf_lift_mv = lever_volts(w.lift_lever);
                    buf_tilt_mv = lever_volts(w.tilt_lever);
                    buf_full    = 1'b1;
                end
            end
        end
        else if (w.packet_id > top_id)
        begin
            // newer packet overwrites the held one
            take_id(w.packet_id);
            buf_lift_mv = lever_volts(w.lift_lever);
            buf_tilt_mv = lever_volts(w.tilt_lever);
        end
        else
            drop_stale();
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        $display("[%0t] cmdrl_checker: word %0d %s: expected %0h, got %0h",
                 $realtime, frames_checked, field, want, got);
    endtask

    task automatic check_frame(input out_word_t got);
        out_word_t want;
        frames_checked++;
        if (got.is_stop)
            stops_checked++;
        if (frames_due.size() == 0)
        begin
            report_mismatch("arrived with nothing expected, sent_count", 32'd0, got.sent_count);
            return;
        end
        want = frames_due.pop_front();
        if (got.lift_down_mv !== want.lift_down_mv)
            report_mismatch("lift_down_mv", want.lift_down_mv, got.lift_down_mv);
        if (got.lift_up_mv !== want.lift_up_mv)
            report_mismatch("lift_up_mv", want.lift_up_mv, got.lift_up_mv);
        if (got.tilt_back_mv !== want.tilt_back_mv)
            report_mismatch("tilt_back_mv", want.tilt_back_mv, got.tilt_back_mv);
        if (got.tilt_fwd_mv !== want.tilt_fwd_mv)
            report_mismatch("tilt_fwd_mv", want.tilt_fwd_mv, got.tilt_fwd_mv);
        if (got.is_stop !== want.is_stop)
            report_mismatch("is_stop", want.is_stop, got.is_stop);
        if (got.lost_count !== want.lost_count)
            report_mismatch("lost_count", want.lost_count, got.lost_count);
        if (got.late_count !== want.late_count)
            report_mismatch("late_count", want.late_count, got.late_count);
        if (got.sent_count !== want.sent_count)
            report_mismatch("sent_count", want.sent_count, got.sent_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap    = SHORT_INTERVAL_RST;
            idle_gap   = LONG_INTERVAL_RST;
            since_send = '0;
            buf_full   = 1'b0;
            top_id     = '0;
            any_id     = 1'b0;
            lost_acc   = '0;
            late_acc   = '0;
            sent_acc   = '0;
            frames_due.delete();
        end
        else
        begin
            // results leave via the result register, so compare before predicting
            if (out_valid && !out_stall)
                check_frame(out_data);
            if (in_valid && !in_stall)
                step_limiter(in_data);
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SHORT_INTERVAL: min_gap  = cfg_data;
                    REG_LONG_INTERVAL:  idle_gap = cfg_data;
                    default: ;
                endcase
            end
        end
        fail_count  <= errors;
        pending     <= frames_due.size();
        frames_seen <= frames_checked;
        stops_seen  <= stops_checked;
    end

endmodule

// File: sim/tb_command_rate_limiter_watchdog_unit.sv
`timescale 1ns / 100ps
// Stimulus and verdict for command_rate_limiter_watchdog_unit; checking is done by
// cmdrl_checker. Depends on cmdrl_pkg, the RTL and sim/cmdrl_checker.sv.
module tb_command_rate_limiter_watchdog_unit;
    import cmdrl_pkg::*;

    localparam int CFG_SETTLE  = 8;
    localparam int DRAIN       = 12;
    localparam int HOLD_CYCLES = 120;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_WORDS = 70;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_word_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_data;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SHORT_INTERVAL;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  hold_req  = 1'b0;

    int fail_count;
    int pending;
    int frames_seen;
    int stops_seen;

    int          words_sent = 0;
    int          settings   = 0;
    bit          choppy     = 1'b0;
    logic [31:0] id_cursor  = '0;

    command_rate_limiter_watchdog_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cmdrl_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .frames_seen (frames_seen),
        .stops_seen  (stops_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (!choppy)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [11:0] pick_lever();
        int v;
        if ($urandom_range(0, 99) < 85)
            v = int'($urandom_range(0, 2500)) - 1250;
        else
        begin
            case ($urandom_range(0, 5))
                0: v = -2048;
                1: v = 2047;
                2: v = -1251;
                3: v = 1251;
                4: v = -1250;
                default: v = 1250;
            endcase
        end
        return 12'(v);
    endfunction

    // lever and id bits of a tick word are ignored, so fill them with junk
    function automatic in_word_t tick_word();
        in_word_t w;
        w.command    = CMD_TICK;
        w.packet_id  = $urandom;
        w.lift_lever = 12'($urandom);
        w.tilt_lever = 12'($urandom);
        return w;
    endfunction

    function automatic in_word_t packet_word(input logic [31:0] id,
                                             input logic signed [11:0] lift,
                                             input logic signed [11:0] tilt);
        in_word_t w;
        w.command    = CMD_PACKET;
        w.packet_id  = id;
        w.lift_lever = lift;
        w.tilt_lever = tilt;
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        gap = pick_gap();
        in_data  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_ticks(input int n);
        for (int k = 0; k < n; k++)
            send_word(tick_word());
    endtask

    task automatic send_packet(input logic [31:0] id, input int lift, input int tilt);
        send_word(packet_word(id, 12'(lift), 12'(tilt)));
    endtask

    // registers change only with the block drained
    task automatic set_intervals(input logic [15:0] min_ticks, input logic [15:0] idle_ticks);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_SHORT_INTERVAL;
        cfg_data  <= min_ticks;
        @(posedge clk);
        cfg_index <= REG_LONG_INTERVAL;
        cfg_data  <= idle_ticks;
        @(posedge clk);
        cfg_write <= 1'b0;
        settings++;
    endtask

    task automatic random_phase(input int n);
        int          r;
        logic [31:0] id;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_word(tick_word());
            else
            begin
                if (r < 85)
                begin
                    id_cursor = id_cursor + (($urandom_range(0, 4) == 0) ?
                                             32'($urandom_range(2, 4)) : 32'd1);
                    id = id_cursor;
                end
                else if (r < 95)
                    id = id_cursor - 32'($urandom_range(0, 4));
                else
                begin
                    id_cursor = id_cursor + 32'($urandom_range(5, 1 << 24));
                    id = id_cursor;
                end
                send_word(packet_word(id, pick_lever(), pick_lever()));
            end
        end
    endtask

    // receiver: random stalls in bursts, plus one long hold-off on request
    initial
    begin : receiver
        int left;
        int span;
        int r;
        bit calm;
        bit squeezed;
        left     = 0;
        span     = 0;
        calm     = 1'b0;
        squeezed = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !squeezed)
            begin
                squeezed = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                left = 0;
            end
            if (span == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
                span = $urandom_range(50, 300);
            end
            span--;
            if (left > 0)
                left--;
            else if (!calm)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    left = 0;
                else if (r < 92)
                    left = $urandom_range(1, 3);
                else
                    left = $urandom_range(10, 40);
            end
            out_stall <= (left != 0);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[%0t] no word moved for %0d cycles", $realtime, QUIET_LIMIT);
                $display("tb_command_rate_limiter_watchdog_unit: FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset intervals 100/2000; first packet books no loss, levers saturate
        choppy = 1'b0;
        send_packet(32'd0, 2047, -2048);
        send_packet(32'd3, 1250, -1250);
        send_packet(32'd3, 0, 0);
        send_packet(32'd1, 0, 0);
        send_ticks(100);
        send_ticks(101);
        send_packet(32'd4, -1, 1);
        id_cursor = 32'd4;

        // short cases with tight intervals, edges of both compares
        set_intervals(16'd2, 16'd5);
        choppy = 1'b1;
        send_ticks(3);
        send_packet(32'd5, 0, 0);
        send_packet(32'd6, -1250, 1250);
        send_ticks(1);
        send_packet(32'd9, 1, -1);
        send_packet(32'd8, 500, 500);
        send_ticks(1);
        send_ticks(5);
        send_ticks(2);
        send_packet(32'd10, -2048, 2047);
        send_ticks(1);
        id_cursor = 32'd10;

        // widest intervals: a held word stays put; the next setting releases it
        set_intervals(16'hFFFF, 16'hFFFF);
        choppy = 1'b0;
        send_packet(32'd11, 777, -777);
        send_ticks(6);
        id_cursor = 32'd11;

        set_intervals(16'd1, 16'd1);
        choppy = ($urandom_range(0, 2) != 0);
        random_phase(PHASE_WORDS);
        set_intervals(16'd2, 16'd7);
        choppy = ($urandom_range(0, 2) != 0);
        random_phase(PHASE_WORDS);
        set_intervals(16'd1, 16'hFFFF);
        choppy = ($urandom_range(0, 2) != 0);
        random_phase(PHASE_WORDS);
        set_intervals(16'hFFFF, 16'd1);
        choppy = ($urandom_range(0, 2) != 0);
        random_phase(PHASE_WORDS);
        set_intervals(16'd4, 16'd30);
        choppy = ($urandom_range(0, 2) != 0);
        random_phase(PHASE_WORDS);
        set_intervals(16'($urandom_range(1, 12)), 16'($urandom_range(1, 60)));
        choppy = ($urandom_range(0, 2) != 0);
        random_phase(PHASE_WORDS);
        set_intervals(16'd3, 16'd3);
        choppy = ($urandom_range(0, 2) != 0);
        random_phase(PHASE_WORDS);

        // back-pressure: results every tick while the receiver holds off
        set_intervals(16'd1, 16'd1);
        choppy   = 1'b0;
        hold_req <= 1'b1;
        random_phase(80);

        // top id last: nothing newer can follow it
        send_packet(32'hFFFF_FFFF, 100, -100);
        send_packet(32'd0, 0, 0);
        send_ticks(4);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("run covered %0d words in, %0d frames checked (%0d stop frames)",
                 words_sent, frames_seen, stops_seen);
        $display("over %0d interval settings, including reset values and both extremes",
                 settings);
        if (fail_count == 0)
            $display("tb_command_rate_limiter_watchdog_unit: PASS");
        else
            $display("tb_command_rate_limiter_watchdog_unit: FAIL");
        $finish;
    end

endmodule
